>>> sv/reflect_refract_ray_unit_core_assert.svh
// -----------------------------------------------------------------------------
// Reflect / refract ray unit: assertion macros
// Shared concurrent assertion forms used by the core.
// -----------------------------------------------------------------------------
`ifndef REFLECT_REFRACT_RAY_UNIT_CORE_ASSERT_SVH
`define REFLECT_REFRACT_RAY_UNIT_CORE_ASSERT_SVH

// same-cycle implication
`define RRU_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rru assertion failed");

// implication after a fixed number of cycles
`define RRU_ASSERT_DLY(lbl, clk, rst_n, ante, dly, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
        else $error("rru latency assertion failed");

`endif

>>> sv/rru_pkg.sv
// -----------------------------------------------------------------------------
// Reflect / refract ray unit package
// Widths, constants, stage payload types and output saturation.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rru_pkg;

    localparam int VEC_W      = 18;
    localparam int POS_W      = 32;
    localparam int IDX_W      = 15;
    localparam int FRAC_BITS  = 16;
    localparam int IDX_FRAC   = 12;
    localparam int ETA_FRAC   = 16;
    // quotient bits of 2^28 / n, n >= 1.0
    localparam int DIV_STAGES = 17;
    localparam int ETA_W      = 19;
    localparam int DOT_W      = 38;
    localparam int SQ_W       = 27;
    localparam int SQ_IN_W    = 2 * SQ_W;
    localparam int SQ_REM_W   = SQ_W + 1;
    localparam int REFL_W     = 26;
    localparam int ERH_W      = 27;
    localparam int EDH_W      = 22;

    localparam logic [IDX_W-1:0] IDX_ONE  = IDX_W'(1 << IDX_FRAC);
    localparam logic [IDX_W-1:0] DIV_REM0 =
        IDX_W'(1 << (IDX_FRAC + ETA_FRAC - DIV_STAGES));
    localparam logic [32:0] DIV_NUM = 33'(1 << (IDX_FRAC + ETA_FRAC));

    localparam logic signed [POS_W-1:0] VEC_MAX = 32'sd131071;
    localparam logic signed [POS_W-1:0] VEC_MIN = -32'sd131072;

    typedef struct packed {
        logic                         opcode;
        logic [2:0][VEC_W-1:0]        dir;
        logic [2:0][VEC_W-1:0]        norm;
        logic [2:0][POS_W-1:0]        pos;
        logic [IDX_W-1:0]             idx;
        logic                         ff;
    } t_div_item;

    typedef struct packed {
        logic                         opcode;
        logic                         tir;
        logic [2:0][VEC_W-1:0]        norm;
        logic [2:0][POS_W-1:0]        pos;
        logic [2:0][REFL_W-1:0]       refl;
        logic [ERH_W-1:0]             erh;
        logic [2:0][EDH_W-1:0]        edh;
    } t_sq_item;

    function automatic logic [VEC_W-1:0] sat_vec(input logic signed [POS_W-1:0] v);
        logic [VEC_W-1:0] res;
        if (v > VEC_MAX) begin
            res = VEC_MAX[VEC_W-1:0];
        end else if (v < VEC_MIN) begin
            res = VEC_MIN[VEC_W-1:0];
        end else begin
            res = v[VEC_W-1:0];
        end
        return res;
    endfunction

endpackage

>>> sv/reflect_refract_ray_unit_core.sv
// -----------------------------------------------------------------------------
// Reflect / refract ray unit core
// Mirror reflection or Snell refraction with total internal reflection fallback.
// -----------------------------------------------------------------------------
// Channel   Direction  Handshake                 Payload
// hit       in         start & !busy             i_opcode, i_dir_*, i_norm_*,
//                                                i_pos_*, i_refr_index, i_front_facing
// ray       out        o_done (one-cycle strobe) o_origin_*, o_out_*, o_total_internal
//
// One hit per cycle while busy is low; results leave in the order that hits were taken.
// Latency is set by the 17-stage 2^28/n divider and the 27-stage square root.
// busy is high only during reset and the first cycle after it.
// Reset is synchronous and flushes all valid bits; results are never held off.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "reflect_refract_ray_unit_core_assert.svh"

module reflect_refract_ray_unit_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              i_opcode,
    input  logic signed [rru_pkg::VEC_W-1:0]  i_dir_x,
    input  logic signed [rru_pkg::VEC_W-1:0]  i_dir_y,
    input  logic signed [rru_pkg::VEC_W-1:0]  i_dir_z,
    input  logic signed [rru_pkg::VEC_W-1:0]  i_norm_x,
    input  logic signed [rru_pkg::VEC_W-1:0]  i_norm_y,
    input  logic signed [rru_pkg::VEC_W-1:0]  i_norm_z,
    input  logic signed [rru_pkg::POS_W-1:0]  i_pos_x,
    input  logic signed [rru_pkg::POS_W-1:0]  i_pos_y,
    input  logic signed [rru_pkg::POS_W-1:0]  i_pos_z,
    input  logic [rru_pkg::IDX_W-1:0]         i_refr_index,
    input  logic                              i_front_facing,
    output logic                              o_done,
    output logic signed [rru_pkg::POS_W-1:0]  o_origin_x,
    output logic signed [rru_pkg::POS_W-1:0]  o_origin_y,
    output logic signed [rru_pkg::POS_W-1:0]  o_origin_z,
    output logic signed [rru_pkg::VEC_W-1:0]  o_out_x,
    output logic signed [rru_pkg::VEC_W-1:0]  o_out_y,
    output logic signed [rru_pkg::VEC_W-1:0]  o_out_z,
    output logic                              o_total_internal
);

    localparam int NDV = rru_pkg::DIV_STAGES;
    localparam int NSQ = rru_pkg::SQ_W;
    localparam int LAT = 1 + NDV + 7 + NSQ + 3;

    logic w_acc;
    logic r_busy;

    assign busy  = r_busy;
    assign w_acc = start & ~r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    // ---------------- input stage ----------------
    logic                r_s0_v;
    rru_pkg::t_div_item  r_s0_it;
    rru_pkg::t_div_item  n_s0_it;

    always_comb begin
        n_s0_it.opcode  = i_opcode;
        n_s0_it.dir     = {i_dir_z, i_dir_y, i_dir_x};
        n_s0_it.norm    = {i_norm_z, i_norm_y, i_norm_x};
        n_s0_it.pos     = {i_pos_z, i_pos_y, i_pos_x};
        n_s0_it.idx     = (i_refr_index < rru_pkg::IDX_ONE) ? rru_pkg::IDX_ONE : i_refr_index;
        n_s0_it.ff      = i_front_facing;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_v <= 1'b0;
        end else begin
            r_s0_v <= w_acc;
        end
        r_s0_it <= n_s0_it;
    end

    // ---------------- 2^28 / n, one quotient bit per stage ----------------
    logic                        r_dv_v   [NDV];
    rru_pkg::t_div_item          r_dv_it  [NDV];
    logic [rru_pkg::IDX_W-1:0]   r_dv_rem [NDV];
    logic [NDV-1:0]              r_dv_quo [NDV];

    genvar gk;
    for (gk = 0; gk < NDV; gk++) begin : g_div
        logic                       v_in;
        rru_pkg::t_div_item         it_in;
        logic [rru_pkg::IDX_W-1:0]  rem_in;
        logic [NDV-1:0]             quo_in;
        logic [rru_pkg::IDX_W:0]    w_sh;
        logic [rru_pkg::IDX_W:0]    w_diff;
        logic                       w_ge;

        if (gk == 0) begin : g_first
            assign v_in   = r_s0_v;
            assign it_in  = r_s0_it;
            assign rem_in = rru_pkg::DIV_REM0;
            assign quo_in = '0;
        end else begin : g_next
            assign v_in   = r_dv_v[gk-1];
            assign it_in  = r_dv_it[gk-1];
            assign rem_in = r_dv_rem[gk-1];
            assign quo_in = r_dv_quo[gk-1];
        end

        assign w_sh   = {rem_in, 1'b0};
        assign w_diff = w_sh - {1'b0, it_in.idx};
        assign w_ge   = (w_sh >= {1'b0, it_in.idx});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_v[gk] <= 1'b0;
            end else begin
                r_dv_v[gk] <= v_in;
            end
            r_dv_it[gk]  <= it_in;
            r_dv_rem[gk] <= w_ge ? w_diff[rru_pkg::IDX_W-1:0] : w_sh[rru_pkg::IDX_W-1:0];
            r_dv_quo[gk] <= {quo_in[NDV-2:0], w_ge};
        end
    end

    // ---------------- E1: eta select, D.N products ----------------
    logic                              r_e1_v;
    rru_pkg::t_div_item                r_e1_it;
    logic [rru_pkg::ETA_W-1:0]         r_e1_eta;
    logic signed [2*rru_pkg::VEC_W-1:0] r_e1_p [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e1_v <= 1'b0;
        end else begin
            r_e1_v <= r_dv_v[NDV-1];
        end
        r_e1_it  <= r_dv_it[NDV-1];
        r_e1_eta <= r_dv_it[NDV-1].ff
                  ? {{(rru_pkg::ETA_W-NDV){1'b0}}, r_dv_quo[NDV-1]}
                  : {r_dv_it[NDV-1].idx, {(rru_pkg::ETA_FRAC-rru_pkg::IDX_FRAC){1'b0}}};
        for (int i = 0; i < 3; i++) begin
            r_e1_p[i] <= $signed(r_dv_it[NDV-1].dir[i]) * $signed(r_dv_it[NDV-1].norm[i]);
        end
    end

    // ---------------- E2: dot sum, eta^2 ----------------
    logic                              r_e2_v;
    rru_pkg::t_div_item                r_e2_it;
    logic [rru_pkg::ETA_W-1:0]         r_e2_eta;
    logic [rru_pkg::DOT_W-1:0]         r_e2_dot;
    logic [2*rru_pkg::ETA_W-1:0]       r_e2_eta2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e2_v <= 1'b0;
        end else begin
            r_e2_v <= r_e1_v;
        end
        r_e2_it   <= r_e1_it;
        r_e2_eta  <= r_e1_eta;
        r_e2_dot  <= {{2{r_e1_p[0][35]}}, r_e1_p[0]} + {{2{r_e1_p[1][35]}}, r_e1_p[1]}
                   + {{2{r_e1_p[2][35]}}, r_e1_p[2]};
        r_e2_eta2 <= r_e1_eta * r_e1_eta;
    end

    // ---------------- E3: d1, rF, e2 ----------------
    logic                  r_e3_v;
    rru_pkg::t_div_item    r_e3_it;
    logic [rru_pkg::ETA_W-1:0] r_e3_eta;
    logic signed [21:0]    r_e3_d1;
    logic signed [22:0]    r_e3_rf;
    logic [21:0]           r_e3_e2;
    logic [rru_pkg::DOT_W:0] w_ndot;

    assign w_ndot = '0 - {r_e2_dot[rru_pkg::DOT_W-1], r_e2_dot};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e3_v <= 1'b0;
        end else begin
            r_e3_v <= r_e2_v;
        end
        r_e3_it  <= r_e2_it;
        r_e3_eta <= r_e2_eta;
        r_e3_d1  <= r_e2_dot[rru_pkg::DOT_W-1:rru_pkg::FRAC_BITS];
        r_e3_rf  <= w_ndot[rru_pkg::DOT_W:rru_pkg::FRAC_BITS];
        r_e3_e2  <= r_e2_eta2[2*rru_pkg::ETA_W-1:rru_pkg::ETA_FRAC];
    end

    // ---------------- E4: products ----------------
    logic                  r_e4_v;
    rru_pkg::t_div_item    r_e4_it;
    logic [21:0]           r_e4_e2;
    logic signed [39:0]    r_e4_rm [3];
    logic signed [37:0]    r_e4_ed [3];
    logic signed [45:0]    r_e4_rr;
    logic signed [42:0]    r_e4_er;
    logic signed [rru_pkg::ETA_W:0] w_eta_s;

    assign w_eta_s = {1'b0, r_e3_eta};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e4_v <= 1'b0;
        end else begin
            r_e4_v <= r_e3_v;
        end
        r_e4_it <= r_e3_it;
        r_e4_e2 <= r_e3_e2;
        r_e4_rr <= r_e3_rf * r_e3_rf;
        r_e4_er <= w_eta_s * r_e3_rf;
        for (int i = 0; i < 3; i++) begin
            r_e4_rm[i] <= r_e3_d1 * $signed(r_e3_it.norm[i]);
            r_e4_ed[i] <= w_eta_s * $signed(r_e3_it.dir[i]);
        end
    end

    // ---------------- E5: reflection, s, scaled terms ----------------
    logic                  r_e5_v;
    rru_pkg::t_sq_item     r_e5_it;
    rru_pkg::t_sq_item     n_e5_it;
    logic [21:0]           r_e5_e2;
    logic signed [30:0]    r_e5_s;

    always_comb begin
        n_e5_it.opcode = r_e4_it.opcode;
        n_e5_it.tir    = 1'b0;
        n_e5_it.norm   = r_e4_it.norm;
        n_e5_it.pos    = r_e4_it.pos;
        n_e5_it.erh    = r_e4_er[42:rru_pkg::FRAC_BITS];
        for (int i = 0; i < 3; i++) begin
            n_e5_it.refl[i] = {{8{r_e4_it.dir[i][rru_pkg::VEC_W-1]}}, r_e4_it.dir[i]}
                            - {r_e4_rm[i][39], r_e4_rm[i][39:rru_pkg::FRAC_BITS], 1'b0};
            n_e5_it.edh[i]  = r_e4_ed[i][37:rru_pkg::ETA_FRAC];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e5_v <= 1'b0;
        end else begin
            r_e5_v <= r_e4_v;
        end
        r_e5_it <= n_e5_it;
        r_e5_e2 <= r_e4_e2;
        r_e5_s  <= 31'sd65536 - {1'b0, r_e4_rr[45:rru_pkg::FRAC_BITS]};
    end

    // ---------------- E6: e2 * s ----------------
    logic                  r_e6_v;
    rru_pkg::t_sq_item     r_e6_it;
    logic signed [53:0]    r_e6_es;
    logic signed [22:0]    w_e2_s;

    assign w_e2_s = {1'b0, r_e5_e2};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e6_v <= 1'b0;
        end else begin
            r_e6_v <= r_e5_v;
        end
        r_e6_it <= r_e5_it;
        r_e6_es <= w_e2_s * r_e5_s;
    end

    // ---------------- E7: c, TIR decision, radicand ----------------
    logic                         r_e7_v;
    rru_pkg::t_sq_item            r_e7_it;
    rru_pkg::t_sq_item            n_e7_it;
    logic [rru_pkg::SQ_IN_W-1:0]  r_e7_rad;
    logic [38:0]                  w_c;

    assign w_c = 39'd65536 - {r_e6_es[53], r_e6_es[53:rru_pkg::ETA_FRAC]};

    always_comb begin
        n_e7_it     = r_e6_it;
        n_e7_it.tir = r_e6_it.opcode & w_c[38];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e7_v <= 1'b0;
        end else begin
            r_e7_v <= r_e6_v;
        end
        r_e7_it  <= n_e7_it;
        r_e7_rad <= w_c[38] ? '0 : {w_c[37:0], {rru_pkg::FRAC_BITS{1'b0}}};
    end

    // ---------------- square root, one root bit per stage ----------------
    logic                           r_sq_v    [NSQ];
    rru_pkg::t_sq_item              r_sq_it   [NSQ];
    logic [rru_pkg::SQ_IN_W-1:0]    r_sq_rad  [NSQ];
    logic [rru_pkg::SQ_REM_W-1:0]   r_sq_rem  [NSQ];
    logic [NSQ-1:0]                 r_sq_root [NSQ];

    for (gk = 0; gk < NSQ; gk++) begin : g_sqrt
        localparam int PI = NSQ - 1 - gk;
        logic                          v_in;
        rru_pkg::t_sq_item             it_in;
        logic [rru_pkg::SQ_IN_W-1:0]   rad_in;
        logic [rru_pkg::SQ_REM_W-1:0]  rem_in;
        logic [NSQ-1:0]                root_in;
        logic [rru_pkg::SQ_REM_W+1:0]  w_rem;
        logic [rru_pkg::SQ_REM_W+1:0]  w_trial;
        logic [rru_pkg::SQ_REM_W+1:0]  w_diff;
        logic                          w_ge;

        if (gk == 0) begin : g_first
            assign v_in    = r_e7_v;
            assign it_in   = r_e7_it;
            assign rad_in  = r_e7_rad;
            assign rem_in  = '0;
            assign root_in = '0;
        end else begin : g_next
            assign v_in    = r_sq_v[gk-1];
            assign it_in   = r_sq_it[gk-1];
            assign rad_in  = r_sq_rad[gk-1];
            assign rem_in  = r_sq_rem[gk-1];
            assign root_in = r_sq_root[gk-1];
        end

        assign w_rem   = {rem_in, rad_in[2*PI+1:2*PI]};
        assign w_trial = {1'b0, root_in, 2'b01};
        assign w_diff  = w_rem - w_trial;
        assign w_ge    = (w_rem >= w_trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_v[gk] <= 1'b0;
            end else begin
                r_sq_v[gk] <= v_in;
            end
            r_sq_it[gk]   <= it_in;
            r_sq_rad[gk]  <= rad_in;
            r_sq_rem[gk]  <= w_ge ? w_diff[rru_pkg::SQ_REM_W-1:0]
                                  : w_rem[rru_pkg::SQ_REM_W-1:0];
            r_sq_root[gk] <= {root_in[NSQ-2:0], w_ge};
        end
    end

    // ---------------- F1: k = eta*r - sqrt(c) ----------------
    logic               r_f1_v;
    rru_pkg::t_sq_item  r_f1_it;
    logic signed [28:0] r_f1_k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_v <= 1'b0;
        end else begin
            r_f1_v <= r_sq_v[NSQ-1];
        end
        r_f1_it <= r_sq_it[NSQ-1];
        r_f1_k  <= {{2{r_sq_it[NSQ-1].erh[rru_pkg::ERH_W-1]}}, r_sq_it[NSQ-1].erh}
                 - {2'b00, r_sq_root[NSQ-1]};
    end

    // ---------------- F2: k * N ----------------
    logic               r_f2_v;
    rru_pkg::t_sq_item  r_f2_it;
    logic signed [46:0] r_f2_kn [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f2_v <= 1'b0;
        end else begin
            r_f2_v <= r_f1_v;
        end
        r_f2_it <= r_f1_it;
        for (int i = 0; i < 3; i++) begin
            r_f2_kn[i] <= r_f1_k * $signed(r_f1_it.norm[i]);
        end
    end

    // ---------------- output stage: select and saturate ----------------
    logic                        r_done;
    logic [rru_pkg::POS_W-1:0]   r_origin [3];
    logic [rru_pkg::VEC_W-1:0]   r_out    [3];
    logic                        r_tir;
    logic signed [rru_pkg::POS_W-1:0] w_res [3];
    logic                        w_use_refr;

    assign w_use_refr = r_f2_it.opcode & ~r_f2_it.tir;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (w_use_refr) begin
                w_res[i] = {{10{r_f2_it.edh[i][rru_pkg::EDH_W-1]}}, r_f2_it.edh[i]}
                         + {r_f2_kn[i][46], r_f2_kn[i][46:rru_pkg::FRAC_BITS]};
            end else begin
                w_res[i] = {{6{r_f2_it.refl[i][rru_pkg::REFL_W-1]}}, r_f2_it.refl[i]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_f2_v;
        end
        r_tir <= r_f2_it.tir;
        for (int i = 0; i < 3; i++) begin
            r_origin[i] <= r_f2_it.pos[i];
            r_out[i]    <= rru_pkg::sat_vec(w_res[i]);
        end
    end

    assign o_done           = r_done;
    assign o_total_internal = r_tir;
    assign o_origin_x       = r_origin[0];
    assign o_origin_y       = r_origin[1];
    assign o_origin_z       = r_origin[2];
    assign o_out_x          = r_out[0];
    assign o_out_y          = r_out[1];
    assign o_out_z          = r_out[2];

    // ---------------- checks ----------------
    logic [32:0] w_chk_dlo;
    logic [32:0] w_chk_dhi;
    logic [55:0] w_chk_q;
    logic [55:0] w_chk_q1;
    logic [55:0] w_chk_rad;
    logic        w_chk_div_v;
    logic        w_chk_div_ok;
    logic        w_chk_sq_ok;

    assign w_chk_dlo = {16'd0, r_dv_quo[NDV-1]} * {18'd0, r_dv_it[NDV-1].idx};
    assign w_chk_dhi = w_chk_dlo + {18'd0, r_dv_it[NDV-1].idx};
    assign w_chk_q   = {29'd0, r_sq_root[NSQ-1]};
    assign w_chk_q1  = w_chk_q + 56'd1;
    assign w_chk_rad = {2'd0, r_sq_rad[NSQ-1]};

    assign w_chk_div_v  = r_dv_v[NDV-1] && r_dv_it[NDV-1].ff;
    assign w_chk_div_ok = (w_chk_dlo <= rru_pkg::DIV_NUM) && (w_chk_dhi > rru_pkg::DIV_NUM);
    assign w_chk_sq_ok  = ((w_chk_q * w_chk_q) <= w_chk_rad)
                       && (w_chk_rad < (w_chk_q1 * w_chk_q1));

    `RRU_ASSERT_DLY(a_latency, i_clk, i_rst_n, w_acc, LAT, o_done)
    `RRU_ASSERT_IMP(a_no_spurious, i_clk, i_rst_n, o_done, $past(w_acc, LAT))
    `RRU_ASSERT_IMP(a_div_exact, i_clk, i_rst_n, w_chk_div_v, w_chk_div_ok)
    `RRU_ASSERT_IMP(a_sqrt_exact, i_clk, i_rst_n, r_sq_v[NSQ-1], w_chk_sq_ok)

endmodule

>>> tb/sv/tb_reflect_refract_ray_unit_core.sv
// -----------------------------------------------------------------------------
// Reflect / refract ray unit core testbench
// Streams surface hits through the core and checks every ray against an
// in-bench fixed-point predictor: directed corners first, then random hits,
// under several sender idle patterns.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_reflect_refract_ray_unit_core;

    localparam int  OP_REFLECT   = 0;
    localparam int  OP_REFRACT   = 1;
    localparam int  N_RANDOM     = 630;
    localparam int  PIPE_LAT     = 55;
    localparam longint CYCLE_CAP = 200000;

    typedef struct {
        logic                              opcode;
        logic signed [rru_pkg::VEC_W-1:0]  dir [3];
        logic signed [rru_pkg::VEC_W-1:0]  norm [3];
        logic signed [rru_pkg::POS_W-1:0]  pos [3];
        logic [rru_pkg::IDX_W-1:0]         idx;
        logic                              ff;
    } t_hit;

    typedef struct {
        logic signed [rru_pkg::POS_W-1:0]  origin [3];
        logic signed [rru_pkg::VEC_W-1:0]  dir [3];
        logic                              tir;
    } t_ray;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    t_hit cur_hit;
    logic o_done;
    logic signed [rru_pkg::POS_W-1:0] o_origin_x, o_origin_y, o_origin_z;
    logic signed [rru_pkg::VEC_W-1:0] o_out_x, o_out_y, o_out_z;
    logic o_total_internal;

    t_hit   hit_q [$];
    t_ray   ray_expect_q [$];
    logic   beat_taken = 1'b0;
    int     n_fail = 0;
    int     n_total = 0;
    int     n_sent = 0;
    longint n_cycles = 0;

    always #10 i_clk = ~i_clk;

    reflect_refract_ray_unit_core uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_opcode(cur_hit.opcode),
        .i_dir_x(cur_hit.dir[0]), .i_dir_y(cur_hit.dir[1]), .i_dir_z(cur_hit.dir[2]),
        .i_norm_x(cur_hit.norm[0]), .i_norm_y(cur_hit.norm[1]),
        .i_norm_z(cur_hit.norm[2]),
        .i_pos_x(cur_hit.pos[0]), .i_pos_y(cur_hit.pos[1]), .i_pos_z(cur_hit.pos[2]),
        .i_refr_index(cur_hit.idx), .i_front_facing(cur_hit.ff),
        .o_done(o_done),
        .o_origin_x(o_origin_x), .o_origin_y(o_origin_y), .o_origin_z(o_origin_z),
        .o_out_x(o_out_x), .o_out_y(o_out_y), .o_out_z(o_out_z),
        .o_total_internal(o_total_internal)
    );

    function automatic longint int_sqrt(longint unsigned x);
        longint unsigned res;
        longint unsigned bt;
        res = 0;
        bt = 64'd1 << 62;
        while (bt > x) bt = bt >> 2;
        while (bt != 0) begin
            if (x >= res + bt) begin
                x = x - (res + bt);
                res = (res >> 1) + bt;
            end else begin
                res = res >> 1;
            end
            bt = bt >> 2;
        end
        return longint'(res);
    endfunction

    function automatic logic signed [rru_pkg::VEC_W-1:0] clamp_dir(longint v);
        if (v > 131071) return 18'sd131071;
        if (v < -131072) return -18'sd131072;
        return v[rru_pkg::VEC_W-1:0];
    endfunction

    // >>> on signed longint floors
    function automatic t_ray trace_ray(t_hit h);
        t_ray   r;
        longint d [3], nv [3], o [3];
        longint dot, d1, eta, rf, s, e2, c, q, k, n;
        dot = 0;
        for (int i = 0; i < 3; i++) begin
            d[i] = longint'(h.dir[i]);
            nv[i] = longint'(h.norm[i]);
            dot += d[i] * nv[i];
        end
        d1 = dot >>> rru_pkg::FRAC_BITS;
        for (int i = 0; i < 3; i++)
            o[i] = d[i] - 2 * ((d1 * nv[i]) >>> rru_pkg::FRAC_BITS);
        r.tir = 1'b0;
        if (h.opcode == OP_REFRACT) begin
            n = longint'(h.idx);
            if (n < (1 << rru_pkg::IDX_FRAC)) n = 1 << rru_pkg::IDX_FRAC;
            if (h.ff) eta = (64'sd1 <<< (rru_pkg::IDX_FRAC + rru_pkg::ETA_FRAC)) / n;
            else eta = n <<< (rru_pkg::ETA_FRAC - rru_pkg::IDX_FRAC);
            rf = (-dot) >>> rru_pkg::FRAC_BITS;
            s = (64'sd1 <<< rru_pkg::FRAC_BITS) - ((rf * rf) >>> rru_pkg::FRAC_BITS);
            e2 = (eta * eta) >>> rru_pkg::ETA_FRAC;
            c = (64'sd1 <<< rru_pkg::FRAC_BITS) - ((e2 * s) >>> rru_pkg::ETA_FRAC);
            if (c < 0) begin
                r.tir = 1'b1;
            end else begin
                q = int_sqrt(longint'(c) << rru_pkg::FRAC_BITS);
                k = ((eta * rf) >>> rru_pkg::ETA_FRAC) - q;
                for (int i = 0; i < 3; i++)
                    o[i] = ((eta * d[i]) >>> rru_pkg::ETA_FRAC)
                         + ((k * nv[i]) >>> rru_pkg::FRAC_BITS);
            end
        end
        for (int i = 0; i < 3; i++) begin
            r.origin[i] = h.pos[i];
            r.dir[i] = clamp_dir(o[i]);
        end
        return r;
    endfunction

    function automatic t_hit make_hit(int op, int dx, int dy, int dz, int nx, int ny,
                                      int nz, int idx, int ff);
        t_hit h;
        h.opcode = op[0];
        h.dir[0] = dx[rru_pkg::VEC_W-1:0];
        h.dir[1] = dy[rru_pkg::VEC_W-1:0];
        h.dir[2] = dz[rru_pkg::VEC_W-1:0];
        h.norm[0] = nx[rru_pkg::VEC_W-1:0];
        h.norm[1] = ny[rru_pkg::VEC_W-1:0];
        h.norm[2] = nz[rru_pkg::VEC_W-1:0];
        for (int i = 0; i < 3; i++) h.pos[i] = $urandom;
        h.idx = idx[rru_pkg::IDX_W-1:0];
        h.ff = ff[0];
        return h;
    endfunction

    function automatic int rand_comp(bit wide);
        if (wide) return int'($urandom_range(0, 262143)) - 131072;
        return int'($urandom_range(0, 131072)) - 65536;
    endfunction

    initial begin
        t_hit h;
        int   mx, mn;
        mx = 131071;
        mn = -131072;
        // directed corners
        hit_q.push_back(make_hit(OP_REFLECT, 0, 0, -65536, 0, 0, 65536, 4096, 1));
        hit_q.push_back(make_hit(OP_REFLECT, mx, mx, mx, mx, mx, mx, 32767, 0));
        hit_q.push_back(make_hit(OP_REFLECT, mn, mn, mn, mn, mn, mn, 0, 1));
        hit_q.push_back(make_hit(OP_REFLECT, mx, mn, mx, mn, mx, mn, 4096, 0));
        hit_q.push_back(make_hit(OP_REFRACT, 0, 0, -65536, 0, 0, 65536, 6144, 1));
        hit_q.push_back(make_hit(OP_REFRACT, 0, 0, -65536, 0, 0, 65536, 6144, 0));
        hit_q.push_back(make_hit(OP_REFRACT, 46341, 0, -46341, 0, 0, 65536, 6144, 0));
        // grazing ray inside a dense medium: total internal reflection
        hit_q.push_back(make_hit(OP_REFRACT, 65536, 0, 0, 0, 65536, 0, 8192, 0));
        // zero direction inside at n = 1.0 leaves the sqrt argument exactly zero
        hit_q.push_back(make_hit(OP_REFRACT, 0, 0, 0, 0, 65536, 0, 4096, 0));
        // index below one clamps to 1.0
        hit_q.push_back(make_hit(OP_REFRACT, 30000, -40000, -20000, 0, 65536, 0, 0, 1));
        hit_q.push_back(make_hit(OP_REFRACT, 30000, -40000, -20000, 0, 65536, 0, 4095, 0));
        hit_q.push_back(make_hit(OP_REFRACT, mx, mx, mx, mn, mn, mn, 32767, 0));
        hit_q.push_back(make_hit(OP_REFRACT, mn, mn, mn, mx, mx, mx, 32767, 1));
        hit_q.push_back(make_hit(OP_REFRACT, mx, mn, 0, mx, mn, 0, 32767, 0));
        h = make_hit(OP_REFLECT, 1, -1, 0, 65536, 0, 0, 4096, 0);
        h.pos[0] = 32'h7fffffff; h.pos[1] = 32'h80000000; h.pos[2] = 32'hffffffff;
        hit_q.push_back(h);
        h.pos[0] = 32'h0; h.pos[1] = 32'h55555555; h.pos[2] = 32'haaaaaaaa;
        hit_q.push_back(h);
        // random hits: mostly physically sized vectors, some full-range noise
        for (int i = 0; i < N_RANDOM; i++) begin
            bit wide;
            int idx;
            wide = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 3) != 0) idx = $urandom_range(4096, 9000);
            else idx = $urandom_range(0, 32767);
            hit_q.push_back(make_hit($urandom_range(0, 1),
                rand_comp(wide), rand_comp(wide), rand_comp(wide),
                rand_comp(wide), rand_comp(wide), rand_comp(wide),
                idx, $urandom_range(0, 1)));
        end
        n_total = hit_q.size();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        while (n_sent != n_total || ray_expect_q.size() != 0) @(posedge i_clk);
        repeat (PIPE_LAT + 10) @(posedge i_clk);
        if (n_fail == 0 && ray_expect_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // driver: new beat at falling edge once the previous one was taken
    always @(negedge i_clk) begin
        int idle_pct;
        case ((n_sent * 4) / (n_total + 1))
            0: idle_pct = 0;
            1: idle_pct = 75;
            2: idle_pct = 0;
            default: idle_pct = 20;
        endcase
        if (!i_rst_n) begin
            start   <= 1'b0;
            cur_hit <= make_hit(OP_REFLECT, 0, 0, 0, 0, 0, 0, 4096, 0);
        end else if (!start || beat_taken) begin
            if (hit_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
                cur_hit <= hit_q.pop_front();
                start <= 1'b1;
            end else begin
                start <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles > CYCLE_CAP) begin
            $display("status: fail");
            $finish;
        end
        beat_taken <= i_rst_n && start && !busy;
        if (i_rst_n && start && !busy) begin
            ray_expect_q.push_back(trace_ray(cur_hit));
            n_sent <= n_sent + 1;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_ray e;
        if (i_rst_n && o_done) begin
            if (ray_expect_q.size() == 0) begin
                $error("unexpected ray beat");
                n_fail++;
            end else begin
                e = ray_expect_q.pop_front();
                if (o_origin_x !== e.origin[0]) begin
                    $error("origin_x exp %0d got %0d", e.origin[0], o_origin_x); n_fail++;
                end
                if (o_origin_y !== e.origin[1]) begin
                    $error("origin_y exp %0d got %0d", e.origin[1], o_origin_y); n_fail++;
                end
                if (o_origin_z !== e.origin[2]) begin
                    $error("origin_z exp %0d got %0d", e.origin[2], o_origin_z); n_fail++;
                end
                if (o_out_x !== e.dir[0]) begin
                    $error("out_x exp %0d got %0d", e.dir[0], o_out_x); n_fail++;
                end
                if (o_out_y !== e.dir[1]) begin
                    $error("out_y exp %0d got %0d", e.dir[1], o_out_y); n_fail++;
                end
                if (o_out_z !== e.dir[2]) begin
                    $error("out_z exp %0d got %0d", e.dir[2], o_out_z); n_fail++;
                end
                if (o_total_internal !== e.tir) begin
                    $error("total_internal exp %0d got %0d", e.tir, o_total_internal);
                    n_fail++;
                end
            end
        end
    end

endmodule

>>> reflect_refract_ray_unit_core.f
+incdir+sv
sv/rru_pkg.sv
sv/reflect_refract_ray_unit_core.sv
tb/sv/tb_reflect_refract_ray_unit_core.sv
